>>> hdl/ole_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, command codes, cell operation codes and the cell control
// struct for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int CMD_W         = 2;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 7;

   localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PREPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd3;

   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_NONE    = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
   localparam logic [OP_W-1:0] OP_PREPEND = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 2'd3;

   typedef struct packed {
      logic               cmp_en;
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] operand;
   } cell_ctl_type;

endpackage
`default_nettype wire

>>> hdl/ordered_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one command per transaction: append at back, insert
//   at front, find, or delete the first equal element. rsp_ channel returns
//   one transaction per command with found, status (insert dropped on full)
//   and the element count after the command.
// Timing:
//   A command steps through accept, scan and update. The cells compare
//   against the value in the accept cycle, the first-match mask is formed
//   from the match vector with one DEPTH-bit subtract in scan, and the cells
//   shift and load in update once the response register is free. One command
//   is in flight at a time: a new one is taken only after the last updates.
// Reset:
//   All cells become invalid and the count clears; cell values are left as is.
// Stall:
//   The response sits in an output register. While it waits, the next
//   command is still accepted and compared; it holds in its update cycle
//   until the pending response is taken.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
   parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ole_pkg::CMD_W-1:0]     req_command,
   input  wire logic signed [ole_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic                               rsp_status,
   output logic      [ole_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [ole_pkg::CMD_W-1:0]     cmd_ff;
   logic [ole_pkg::VALUE_W-1:0]   opval_ff;
   logic [CW-1:0]                 count_ff, count_in;
   logic [DEPTH-1:0]              sel_ff;
   logic                          found_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_status_ff;
   logic [ole_pkg::COUNT_W-1:0]   rsp_count_ff;

   logic                          accept;
   logic                          apply_go;
   logic                          full;
   logic                          res_found, res_status;
   logic [DEPTH-1:0]              match_vec, valid_vec, match_dec;
   logic [DEPTH-1:0]              low_mask, first_hot;
   ole_pkg::cell_ctl_type         ctl;
   logic [ole_pkg::VALUE_W-1:0]   cell_value [DEPTH];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign apply_go  = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign full      = (count_ff == CW'(DEPTH));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_SCAN;
         S_SCAN:  state_in = S_APPLY;
         S_APPLY: if (apply_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // first match mask: cells at or beyond the front-most match
   assign match_dec = match_vec - DEPTH'(1);
   assign low_mask  = match_vec ^ match_dec;
   assign first_hot = match_vec & ~match_dec;

   always_comb begin
      ctl.cmp_en  = accept;
      ctl.operand = accept ? req_value : opval_ff;
      ctl.op      = ole_pkg::OP_NONE;
      count_in    = count_ff;
      res_found   = 1'b0;
      res_status  = 1'b0;
      case (cmd_ff)
         ole_pkg::CMD_APPEND, ole_pkg::CMD_PREPEND: begin
            if (full) begin
               res_status = 1'b1;
            end else begin
               ctl.op   = (cmd_ff == ole_pkg::CMD_APPEND) ? ole_pkg::OP_APPEND
                                                          : ole_pkg::OP_PREPEND;
               count_in = count_ff + CW'(1);
            end
         end
         ole_pkg::CMD_FIND: begin
            res_found = found_ff;
         end
         ole_pkg::CMD_DELETE: begin
            res_found = found_ff;
            if (found_ff) begin
               ctl.op   = ole_pkg::OP_DELETE;
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
      if (!apply_go) begin
         ctl.op   = ole_pkg::OP_NONE;
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         opval_ff <= req_value;
      end
      if (state_ff == S_SCAN) begin
         sel_ff   <= ~low_mask | first_hot;
         found_ff <= |match_vec;
      end
      if (apply_go) begin
         rsp_found_ff  <= res_found;
         rsp_status_ff <= res_status;
         rsp_count_ff  <= ole_pkg::COUNT_W'(count_in);
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ole_pkg::VALUE_W-1:0] left_value, right_value;
      logic                        left_valid, right_valid;

      if (i == 0) begin : g_first
         assign left_value = ctl.operand;
         assign left_valid = 1'b1;
      end else begin : g_inner_l
         assign left_value = cell_value[i-1];
         assign left_valid = valid_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_r
         assign right_value = cell_value[i+1];
         assign right_valid = valid_vec[i+1];
      end

      ole_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .del_sel     (sel_ff[i]),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .value_out   (cell_value[i]),
         .valid_out   (valid_vec[i]),
         .match_out   (match_vec[i])
      );
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above depth");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell valid flags disagree with element count");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_APPLY)
      else $error("response raised outside update cycle");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_status_ff))
      else $error("found and dropped flagged together");
`endif

endmodule
`default_nettype wire

>>> hdl/ole_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ole_cell
// One list cell: holds a value and its valid flag, compares against the
// broadcast operand and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module ole_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ole_pkg::cell_ctl_type         ctl,
   input  wire logic                          del_sel,
   input  wire logic [ole_pkg::VALUE_W-1:0]   left_value,
   input  wire logic                          left_valid,
   input  wire logic [ole_pkg::VALUE_W-1:0]   right_value,
   input  wire logic                          right_valid,
   output logic      [ole_pkg::VALUE_W-1:0]   value_out,
   output logic                               valid_out,
   output logic                               match_out
);

   logic [ole_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                        valid_ff, valid_in;
   logic                        match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctl.op)
         ole_pkg::OP_APPEND: begin
            if (!valid_ff && left_valid) begin
               value_in = ctl.operand;
               valid_in = 1'b1;
            end
         end
         ole_pkg::OP_PREPEND: begin
            value_in = left_value;
            valid_in = left_valid;
         end
         ole_pkg::OP_DELETE: begin
            if (del_sel) begin
               value_in = right_value;
               valid_in = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   assign match_in = ctl.cmp_en ? (valid_ff && (value_ff == ctl.operand)) : match_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value_out = value_ff;
   assign valid_out = valid_ff;
   assign match_out = match_ff;

endmodule
`default_nettype wire
